// ----- hw/rtl/pcd_pkg.sv -----
// Package with fixed-point constants, register indexes and reset values for the progressive crossing divider.
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  // Fixed-point reference points (threshold is unsigned Q8.16)
  localparam logic [23:0] ONE_Q16    = 24'h01_0000;
  localparam logic [23:0] HOLD_LEVEL = 24'h7F_0000;  // 127.0
  localparam logic [15:0] CENTER     = 16'h8000;
  localparam logic [24:0] SLEW_TOP   = 25'h100_0000; // 1.0 in Q0.24

  // Configuration register indexes
  localparam logic [1:0] REG_THRESHOLD_DECAY = 2'd0;
  localparam logic [1:0] REG_HOLD_LIMIT      = 2'd1;
  localparam logic [1:0] REG_SLEW_RATE       = 2'd2;

  // Configuration reset values
  localparam logic [15:0] RST_THRESHOLD_DECAY = 16'd65470;
  localparam logic [15:0] RST_HOLD_LIMIT      = 16'd2000;
  localparam logic [15:0] RST_SLEW_RATE       = 16'd66;

endpackage

`default_nettype wire

// ----- hw/rtl/progressive_crossing_divider.sv -----
// Top level of the progressive crossing divider: crossing counter, threshold, hold and slew.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  s_tdata[15:0]  = sample
//  m_*       out  m_tvalid/m_tready  m_tdata[23:0]  = slewed_out[15:0], gate[16], zero pad
//  cfg_*     in   cfg_we             cfg_addr[1:0] register index, cfg_data[15:0]
//
// One request per clock while s_tready is high: every state update for a sample happens in the cycle
// it is accepted, between the state registers and the output register.
// The result shows up on m_* in the cycle after its request is accepted.
// The longest path is the Q8.16 x Q0.16 decay multiply feeding the floor and hold compares.
// rst is synchronous, active high; it loads the config registers with their
// defaults, the threshold with 1.0 and clears all other state but the output payload.
// A stalled output holds its result; s_tready stays high as long as the output
// register is empty or is being drained in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module progressive_crossing_divider #(
  parameter int THRESHOLD_CAP = 128  // 2..255, threshold ceiling in whole units
) (
  input  wire         clk,
  input  wire         rst,
  // sample stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [15:0] s_tdata,   // [15:0] sample
  // result stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [15:0] slewed_out, [16] gate, [23:17] zero
  // config write port
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [15:0] cfg_data
);

  // threshold ceiling in Q8.16
  localparam logic [23:0] CAP_Q16 = {8'(THRESHOLD_CAP), 16'd0};

  // config registers
  logic [15:0] threshold_decay;
  logic [15:0] hold_limit;
  logic [15:0] slew_rate;

  // block state
  logic        previous_side;
  logic [7:0]  crossing_count;
  logic [23:0] threshold;
  logic        gate_level;
  logic [15:0] hold_ticks;
  logic [23:0] slewed_level;

  // output register
  logic        out_valid;
  logic [15:0] out_slewed;
  logic        out_gate;

  // next values
  logic        previous_side_next;
  logic [7:0]  crossing_count_next;
  logic [23:0] threshold_next;
  logic        gate_level_next;
  logic [15:0] hold_ticks_next;
  logic [23:0] slewed_level_next;

  // intermediates
  logic               s_accept;
  logic               side;
  logic [7:0]         count_mid;
  logic               fire;
  logic [24:0]        grown;
  logic [39:0]        decay_prod;
  logic [23:0]        decayed;
  logic [23:0]        t_mid;
  logic [15:0]        hold_inc;
  logic signed [25:0] slew_diff;
  logic signed [42:0] slew_prod;
  logic signed [42:0] slew_step;
  logic [25:0]        slew_sum;

  // Output register frees itself when drained, so a new request can enter
  // in the same cycle the old result leaves.
  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_gate, out_slewed};

  // config writes; an unused index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_decay <= pcd_pkg::RST_THRESHOLD_DECAY;
      hold_limit      <= pcd_pkg::RST_HOLD_LIMIT;
      slew_rate       <= pcd_pkg::RST_SLEW_RATE;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcd_pkg::REG_THRESHOLD_DECAY: threshold_decay <= cfg_data;
        pcd_pkg::REG_HOLD_LIMIT:      hold_limit      <= cfg_data;
        pcd_pkg::REG_SLEW_RATE:       slew_rate       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    // center crossing, count saturates at 255
    side      = s_tdata > pcd_pkg::CENTER;
    count_mid = crossing_count;
    if (side != previous_side && crossing_count != 8'hFF) begin
      count_mid = crossing_count + 8'd1;
    end
    previous_side_next = side;

    // fire when count reaches the threshold
    fire       = {count_mid, 16'd0} >= threshold;
    grown      = {1'b0, threshold} + {3'd0, threshold[23:2]};  // t * 1.25
    decay_prod = {16'd0, threshold} * {24'd0, threshold_decay};
    decayed    = decay_prod[39:16];

    gate_level_next     = gate_level;
    crossing_count_next = count_mid;
    t_mid               = threshold;
    if (fire) begin
      gate_level_next     = !gate_level;
      crossing_count_next = 8'd0;
      t_mid = (grown < {1'b0, CAP_Q16}) ? grown[23:0] : CAP_Q16;
    end else if (threshold > pcd_pkg::ONE_Q16) begin
      t_mid = (decayed > pcd_pkg::ONE_Q16) ? decayed : pcd_pkg::ONE_Q16;
    end

    // time spent near the top snaps the threshold back to 1.0
    hold_inc        = (hold_ticks != 16'hFFFF) ? hold_ticks + 16'd1 : hold_ticks;
    threshold_next  = t_mid;
    hold_ticks_next = 16'd0;
    if (t_mid >= pcd_pkg::HOLD_LEVEL) begin
      hold_ticks_next = hold_inc;
      if (hold_inc > hold_limit) begin
        threshold_next  = pcd_pkg::ONE_Q16;
        hold_ticks_next = 16'd0;
      end
    end

    // one-pole slew toward 0 or 1.0 (Q0.24), floor shift
    slew_diff = $signed({1'b0, (gate_level_next ? pcd_pkg::SLEW_TOP : 25'd0)})
              - $signed({2'b00, slewed_level});
    slew_prod = 43'(slew_diff) * 43'($signed({1'b0, slew_rate}));
    slew_step = slew_prod >>> 16;
    slew_sum  = {2'b00, slewed_level} + slew_step[25:0];
    slewed_level_next = slew_sum[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_side  <= 1'b0;
      crossing_count <= 8'd0;
      threshold      <= pcd_pkg::ONE_Q16;
      gate_level     <= 1'b0;
      hold_ticks     <= 16'd0;
      slewed_level   <= 24'd0;
    end else if (s_accept) begin
      previous_side  <= previous_side_next;
      crossing_count <= crossing_count_next;
      threshold      <= threshold_next;
      gate_level     <= gate_level_next;
      hold_ticks     <= hold_ticks_next;
      slewed_level   <= slewed_level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (s_accept) begin
      out_slewed <= slewed_level_next[23:8];
      out_gate   <= gate_level_next;
    end
  end

  a_thr_floor: assert property (@(posedge clk) disable iff (rst)
    threshold >= pcd_pkg::ONE_Q16)
    else $error("threshold below 1.0");

  a_thr_cap: assert property (@(posedge clk) disable iff (rst)
    threshold <= CAP_Q16 || threshold == pcd_pkg::ONE_Q16)
    else $error("threshold above cap");

  a_hold_top: assert property (@(posedge clk) disable iff (rst)
    hold_ticks != 16'd0 |-> threshold >= pcd_pkg::HOLD_LEVEL)
    else $error("hold counter running below hold level");

  a_gate_idle: assert property (@(posedge clk) disable iff (rst)
    !s_accept |=> $stable(gate_level))
    else $error("gate changed without a request");

endmodule

`default_nettype wire
